[hdl/mcfir_pkg.sv]
// shared constants, types and address helper for the multichannel fir filter
package mcfir_pkg;

  localparam int TAPS     = 32;
  localparam int CHANNELS = 4;
  localparam int IN_CH    = 4;
  localparam int SAMP_W   = 10;
  localparam int COEF_W   = 16;
  localparam int OUT_W    = 16;
  localparam int FRAC     = 15;
  localparam int PROD_W   = COEF_W + SAMP_W + 1;
  localparam int TAP_W    = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DEPTH    = CHANNELS * TAPS;
  localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ACC_W    = (PROD_W + TAP_W + 1 > 32) ? PROD_W + TAP_W + 1 : 32;

  localparam logic OP_SAMPLE_SET = 1'b0;
  localparam logic OP_COEF_WRITE = 1'b1;

  typedef struct packed {
    logic              clear;
    logic [ADDR_W-1:0] clear_addr;
    logic              load_in;
    logic              coef_wr;
    logic              samp_wr;
    logic              rd;
    logic              acc_clr;
    logic              emit;
    logic              last;
    logic [CH_W-1:0]   chan;
    logic [TAP_W-1:0]  pos;
    logic [TAP_W-1:0]  tap;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic out_free;
  } status_t;

  function automatic logic [ADDR_W-1:0] mem_addr(input logic [CH_W-1:0] ch,
                                                 input logic [TAP_W-1:0] idx);
    return ADDR_W'(int'(ch) * TAPS + int'(idx));
  endfunction

endpackage

[hdl/mcfir_ram.sv]
// generic single-port ram with registered read
module mcfir_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

[hdl/mcfir_ctrl.sv]
// sequencer for clearing, sample storage and the shared multiply-accumulate
module mcfir_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_op,
  output logic               in_stall,
  input  mcfir_pkg::status_t status,
  output mcfir_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WRITE,
    S_MAC,
    S_DRAIN
  } state_t;

  state_t                         state_r, state_nxt;
  logic [mcfir_pkg::ADDR_W-1:0]   clr_r, clr_nxt;
  logic [mcfir_pkg::TAP_W-1:0]    wp_r, wp_nxt;
  logic [mcfir_pkg::TAP_W-1:0]    tap_r, tap_nxt;
  logic [mcfir_pkg::TAP_W-1:0]    pos_r, pos_nxt;
  logic [mcfir_pkg::CH_W-1:0]     chan_r, chan_nxt;
  logic                           accept;
  logic                           last_chan;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = (state_r == S_IDLE) && in_valid;
  assign last_chan = (chan_r == mcfir_pkg::CH_W'(mcfir_pkg::CHANNELS - 1));

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    wp_nxt    = wp_r;
    tap_nxt   = tap_r;
    pos_nxt   = pos_r;
    chan_nxt  = chan_r;

    cmd            = '0;
    cmd.clear_addr = clr_r;
    cmd.chan       = chan_r;
    cmd.pos        = pos_r;
    cmd.tap        = tap_r;
    cmd.last       = last_chan;

    case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == mcfir_pkg::ADDR_W'(mcfir_pkg::DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (in_op == mcfir_pkg::OP_COEF_WRITE) begin
            cmd.coef_wr = 1'b1;
          end else begin
            cmd.load_in = 1'b1;
            wp_nxt      = (wp_r == mcfir_pkg::TAP_W'(mcfir_pkg::TAPS - 1)) ? '0 : wp_r + 1'b1;
            chan_nxt    = '0;
            state_nxt   = S_WRITE;
          end
        end
      end
      S_WRITE: begin
        cmd.samp_wr = 1'b1;
        cmd.pos     = wp_r;
        if (last_chan) begin
          chan_nxt  = '0;
          tap_nxt   = '0;
          pos_nxt   = wp_r;
          state_nxt = S_MAC;
        end else begin
          chan_nxt = chan_r + 1'b1;
        end
      end
      S_MAC: begin
        cmd.rd      = 1'b1;
        cmd.acc_clr = (tap_r == '0);
        tap_nxt     = tap_r + 1'b1;
        pos_nxt     = (pos_r == '0) ? mcfir_pkg::TAP_W'(mcfir_pkg::TAPS - 1) : pos_r - 1'b1;
        if (tap_r == mcfir_pkg::TAP_W'(mcfir_pkg::TAPS - 1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!status.busy && status.out_free) begin
          cmd.emit = 1'b1;
          if (last_chan) begin
            state_nxt = S_IDLE;
          end else begin
            chan_nxt  = chan_r + 1'b1;
            tap_nxt   = '0;
            pos_nxt   = wp_r;
            state_nxt = S_MAC;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      wp_r    <= '0;
      tap_r   <= '0;
      pos_r   <= '0;
      chan_r  <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      wp_r    <= wp_nxt;
      tap_r   <= tap_nxt;
      pos_r   <= pos_nxt;
      chan_r  <= chan_nxt;
    end
  end

endmodule

[hdl/mcfir_dp.sv]
// datapath: sample and coefficient stores, multiply-accumulate and result register
module mcfir_dp (
  input  logic                                                 clk,
  input  logic                                                 rst_n,
  input  mcfir_pkg::cmd_t                                      cmd,
  output mcfir_pkg::status_t                                   status,
  input  logic [mcfir_pkg::IN_CH-1:0][mcfir_pkg::SAMP_W-1:0]   in_samp,
  input  logic [1:0]                                           in_coef_channel,
  input  logic [4:0]                                           in_coef_tap,
  input  logic signed [mcfir_pkg::COEF_W-1:0]                  in_coef_value,
  output logic                                                 out_valid,
  input  logic                                                 out_stall,
  output logic [1:0]                                           out_channel,
  output logic [mcfir_pkg::SAMP_W-1:0]                         out_raw_sample,
  output logic signed [mcfir_pkg::OUT_W-1:0]                   out_filtered,
  output logic                                                 out_last
);

  logic [mcfir_pkg::SAMP_W-1:0]        samp_r [mcfir_pkg::CHANNELS];
  logic                                coef_in_range;
  logic                                coef_we, samp_we;
  logic [mcfir_pkg::ADDR_W-1:0]        coef_addr, samp_addr;
  logic [mcfir_pkg::COEF_W-1:0]        coef_wdata, coef_rdata;
  logic [mcfir_pkg::SAMP_W-1:0]        samp_wdata, samp_rdata;
  logic                                v1_r, v2_r;
  logic signed [mcfir_pkg::PROD_W-1:0] prod_r;
  logic signed [mcfir_pkg::ACC_W-1:0]  acc_r;
  logic                                out_valid_r;
  logic [1:0]                          out_channel_r;
  logic [mcfir_pkg::SAMP_W-1:0]        out_raw_r;
  logic signed [mcfir_pkg::OUT_W-1:0]  out_filt_r;
  logic                                out_last_r;

  assign coef_in_range = (int'(in_coef_channel) < mcfir_pkg::CHANNELS) &&
                         (int'(in_coef_tap) < mcfir_pkg::TAPS);

  assign coef_we    = cmd.clear || (cmd.coef_wr && coef_in_range);
  assign coef_wdata = cmd.clear ? '0 : in_coef_value;
  always_comb begin
    if (cmd.clear) begin
      coef_addr = cmd.clear_addr;
    end else if (cmd.coef_wr) begin
      coef_addr = mcfir_pkg::mem_addr(mcfir_pkg::CH_W'(in_coef_channel),
                                      mcfir_pkg::TAP_W'(in_coef_tap));
    end else begin
      coef_addr = mcfir_pkg::mem_addr(cmd.chan, cmd.tap);
    end
  end

  assign samp_we    = cmd.clear || cmd.samp_wr;
  assign samp_wdata = cmd.clear ? '0 : samp_r[cmd.chan];
  assign samp_addr  = cmd.clear ? cmd.clear_addr : mcfir_pkg::mem_addr(cmd.chan, cmd.pos);

  mcfir_ram #(
    .WIDTH(mcfir_pkg::COEF_W),
    .DEPTH(mcfir_pkg::DEPTH)
  ) u_coef_ram (
    .clk  (clk),
    .we   (coef_we),
    .addr (coef_addr),
    .wdata(coef_wdata),
    .rdata(coef_rdata)
  );

  mcfir_ram #(
    .WIDTH(mcfir_pkg::SAMP_W),
    .DEPTH(mcfir_pkg::DEPTH)
  ) u_samp_ram (
    .clk  (clk),
    .we   (samp_we),
    .addr (samp_addr),
    .wdata(samp_wdata),
    .rdata(samp_rdata)
  );

  // newest samples, also the raw value of each result
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      for (int c = 0; c < mcfir_pkg::CHANNELS; c++) begin
        samp_r[c] <= in_samp[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.rd;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v1_r) begin
      prod_r <= $signed(coef_rdata) * $signed({1'b0, samp_rdata});
    end
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (v2_r) begin
      acc_r <= acc_r + mcfir_pkg::ACC_W'(prod_r);
    end
  end

  assign status.busy     = v1_r || v2_r;
  assign status.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_channel_r <= 2'(cmd.chan);
      out_raw_r     <= samp_r[cmd.chan];
      out_filt_r    <= acc_r[mcfir_pkg::FRAC+mcfir_pkg::OUT_W-1:mcfir_pkg::FRAC];
      out_last_r    <= cmd.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_channel    = out_channel_r;
  assign out_raw_sample = out_raw_r;
  assign out_filtered   = out_filt_r;
  assign out_last       = out_last_r;

endmodule

[hdl/multichannel_fir_filter_unit.sv]
// top level of the four-channel q15 fir filter
// coefficient write: result-free; the next transfer is taken in the following cycle
// sample set: stored channel by channel, then each channel in turn runs through the one
// shared multiplier and ram read port; the input stays stalled until the last result is emitted
// results leave through an output register, one per channel in channel order
// reset: synchronous, active low; a pass over all 128 addresses then zeroes both stores, input stalled
module multichannel_fir_filter_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_op,
  input  logic [mcfir_pkg::SAMP_W-1:0]        in_sample_ch0,
  input  logic [mcfir_pkg::SAMP_W-1:0]        in_sample_ch1,
  input  logic [mcfir_pkg::SAMP_W-1:0]        in_sample_ch2,
  input  logic [mcfir_pkg::SAMP_W-1:0]        in_sample_ch3,
  input  logic [1:0]                          in_coef_channel,
  input  logic [4:0]                          in_coef_tap,
  input  logic signed [mcfir_pkg::COEF_W-1:0] in_coef_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          out_channel,
  output logic [mcfir_pkg::SAMP_W-1:0]        out_raw_sample,
  output logic signed [mcfir_pkg::OUT_W-1:0]  out_filtered,
  output logic                                out_last
);

  mcfir_pkg::cmd_t                                    cmd;
  mcfir_pkg::status_t                                 status;
  logic [mcfir_pkg::IN_CH-1:0][mcfir_pkg::SAMP_W-1:0] in_samp;

  assign in_samp = {in_sample_ch3, in_sample_ch2, in_sample_ch1, in_sample_ch0};

  mcfir_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_op   (in_op),
    .in_stall(in_stall),
    .status  (status),
    .cmd     (cmd)
  );

  mcfir_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_samp        (in_samp),
    .in_coef_channel(in_coef_channel),
    .in_coef_tap    (in_coef_tap),
    .in_coef_value  (in_coef_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_channel    (out_channel),
    .out_raw_sample (out_raw_sample),
    .out_filtered   (out_filtered),
    .out_last       (out_last)
  );

endmodule

[hdl/mcfir_chk.sv]
// port-level checks on the fir filter, bound to the top level
module mcfir_chk (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                in_op,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [1:0]                          out_channel,
  input logic [mcfir_pkg::SAMP_W-1:0]        out_raw_sample,
  input logic signed [mcfir_pkg::OUT_W-1:0]  out_filtered,
  input logic                                out_last
);

  a_last_on_final_channel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_channel == 2'(mcfir_pkg::CHANNELS - 1))
    else $error("last flag on a channel other than the final one");

  a_final_has_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_channel == 2'(mcfir_pkg::CHANNELS - 1) |-> out_last)
    else $error("final channel result without last flag");

  a_sample_set_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_op == mcfir_pkg::OP_SAMPLE_SET |=> in_stall)
    else $error("input not stalled while a sample set is in work");

  a_coef_write_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_op == mcfir_pkg::OP_COEF_WRITE |=> !in_stall)
    else $error("coefficient write left the input stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_filtered) &&
      $stable(out_raw_sample) && $stable(out_channel) && $stable(out_last))
    else $error("stalled result changed before transfer");

endmodule

bind multichannel_fir_filter_unit mcfir_chk u_mcfir_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_op         (in_op),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_channel   (out_channel),
  .out_raw_sample(out_raw_sample),
  .out_filtered  (out_filtered),
  .out_last      (out_last)
);

[tb/mcfir_checker.sv]
// checker for the multichannel fir filter: tracks all four channels, predicts results and compares
`timescale 1ns / 100ps

module mcfir_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic                                in_op,
  input  logic [mcfir_pkg::SAMP_W-1:0]        in_sample_ch0,
  input  logic [mcfir_pkg::SAMP_W-1:0]        in_sample_ch1,
  input  logic [mcfir_pkg::SAMP_W-1:0]        in_sample_ch2,
  input  logic [mcfir_pkg::SAMP_W-1:0]        in_sample_ch3,
  input  logic [1:0]                          in_coef_channel,
  input  logic [4:0]                          in_coef_tap,
  input  logic signed [mcfir_pkg::COEF_W-1:0] in_coef_value,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic [1:0]                          out_channel,
  input  logic [mcfir_pkg::SAMP_W-1:0]        out_raw_sample,
  input  logic signed [mcfir_pkg::OUT_W-1:0]  out_filtered,
  input  logic                                out_last,
  output int                                  fail_count,
  output int                                  outstanding,
  output int                                  checked
);

  typedef struct packed {
    logic [1:0]                         channel;
    logic [mcfir_pkg::SAMP_W-1:0]       raw_sample;
    logic signed [mcfir_pkg::OUT_W-1:0] filtered;
    logic                               last;
  } fir_result_t;

  logic [mcfir_pkg::SAMP_W-1:0]        sample_hist [mcfir_pkg::CHANNELS][mcfir_pkg::TAPS];
  logic signed [mcfir_pkg::COEF_W-1:0] coef_table  [mcfir_pkg::CHANNELS][mcfir_pkg::TAPS];
  logic [mcfir_pkg::TAP_W-1:0]         newest;
  fir_result_t                         fir_result_q[$];

  function automatic logic signed [mcfir_pkg::OUT_W-1:0] filter_sum(int ch);
    logic signed [63:0]          acc;
    logic [mcfir_pkg::TAP_W-1:0] idx;
    acc = '0;
    idx = newest;
    for (int k = 0; k < mcfir_pkg::TAPS; k++) begin
      acc = acc + longint'(coef_table[ch][k]) * longint'(sample_hist[ch][idx]);
      idx = (idx == 0) ? mcfir_pkg::TAP_W'(mcfir_pkg::TAPS - 1) : idx - 1'b1;
    end
    return acc[mcfir_pkg::FRAC+mcfir_pkg::OUT_W-1:mcfir_pkg::FRAC];
  endfunction

  task automatic check_field(string field, int want, int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    logic [mcfir_pkg::SAMP_W-1:0] fresh [mcfir_pkg::IN_CH];
    fir_result_t                  res;
    if (!rst_n) begin
      for (int c = 0; c < mcfir_pkg::CHANNELS; c++) begin
        for (int k = 0; k < mcfir_pkg::TAPS; k++) begin
          sample_hist[c][k] = '0;
          coef_table[c][k]  = '0;
        end
      end
      newest = '0;
      fir_result_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (fir_result_q.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual channel %0d filtered %0d",
                   $time, out_channel, out_filtered);
          fail_count++;
        end else begin
          res = fir_result_q.pop_front();
          check_field("channel", res.channel, out_channel);
          check_field("raw_sample", res.raw_sample, out_raw_sample);
          check_field("filtered", res.filtered, out_filtered);
          check_field("last", res.last, out_last);
          checked++;
        end
      end
      if (in_valid && !in_stall) begin
        if (in_op == mcfir_pkg::OP_COEF_WRITE) begin
          if (int'(in_coef_channel) < mcfir_pkg::CHANNELS &&
              int'(in_coef_tap) < mcfir_pkg::TAPS)
            coef_table[in_coef_channel][in_coef_tap] = in_coef_value;
        end else begin
          fresh  = '{in_sample_ch0, in_sample_ch1, in_sample_ch2, in_sample_ch3};
          newest = (int'(newest) == mcfir_pkg::TAPS - 1) ? '0 : newest + 1'b1;
          for (int c = 0; c < mcfir_pkg::CHANNELS; c++)
            sample_hist[c][newest] = fresh[c];
          for (int c = 0; c < mcfir_pkg::CHANNELS; c++) begin
            res.channel    = 2'(c);
            res.raw_sample = sample_hist[c][newest];
            res.filtered   = filter_sum(c);
            res.last       = (c == mcfir_pkg::CHANNELS - 1);
            fir_result_q.push_back(res);
          end
        end
      end
    end
    outstanding = fir_result_q.size();
  end

endmodule

[tb/tb.sv]
// top of the multichannel fir filter testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module tb;

  localparam int PHASE_ITEMS = 114;

  logic                                clk;
  logic                                rst_n;
  logic                                in_valid;
  logic                                in_stall;
  logic                                in_op;
  logic [mcfir_pkg::SAMP_W-1:0]        in_sample_ch0;
  logic [mcfir_pkg::SAMP_W-1:0]        in_sample_ch1;
  logic [mcfir_pkg::SAMP_W-1:0]        in_sample_ch2;
  logic [mcfir_pkg::SAMP_W-1:0]        in_sample_ch3;
  logic [1:0]                          in_coef_channel;
  logic [4:0]                          in_coef_tap;
  logic signed [mcfir_pkg::COEF_W-1:0] in_coef_value;
  logic                                out_valid;
  logic                                out_stall;
  logic [1:0]                          out_channel;
  logic [mcfir_pkg::SAMP_W-1:0]        out_raw_sample;
  logic signed [mcfir_pkg::OUT_W-1:0]  out_filtered;
  logic                                out_last;

  int fail_count;
  int outstanding;
  int checked;
  int idle_pct;
  int stall_pct;
  int sets_sent;
  int coefs_sent;
  bit hold_armed;

  multichannel_fir_filter_unit u_dut (.*);

  mcfir_checker u_checker (.*);

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  // receiver side: random stalls, plus one long hold-off when armed
  initial begin : receiver
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_armed && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 600;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  function automatic logic [mcfir_pkg::SAMP_W-1:0] pick_sample();
    int r;
    r = $urandom_range(99);
    if (r < 15) return '0;
    if (r < 30) return '1;
    return mcfir_pkg::SAMP_W'($urandom);
  endfunction

  function automatic logic signed [mcfir_pkg::COEF_W-1:0] pick_coef();
    case ($urandom_range(7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return -16'sd1;
      default: return mcfir_pkg::COEF_W'($urandom);
    endcase
  endfunction

  task automatic send_item(input logic op, input logic [mcfir_pkg::SAMP_W-1:0] s0, s1, s2, s3,
                           input logic [1:0] ch, input logic [4:0] tap,
                           input logic signed [mcfir_pkg::COEF_W-1:0] value);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_op           <= op;
    in_sample_ch0   <= s0;
    in_sample_ch1   <= s1;
    in_sample_ch2   <= s2;
    in_sample_ch3   <= s3;
    in_coef_channel <= ch;
    in_coef_tap     <= tap;
    in_coef_value   <= value;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_set(input logic [mcfir_pkg::SAMP_W-1:0] s0, s1, s2, s3);
    send_item(mcfir_pkg::OP_SAMPLE_SET, s0, s1, s2, s3, 2'($urandom), 5'($urandom),
              mcfir_pkg::COEF_W'($urandom));
    sets_sent++;
  endtask

  task automatic send_coef(input logic [1:0] ch, input logic [4:0] tap,
                           input logic signed [mcfir_pkg::COEF_W-1:0] value);
    send_item(mcfir_pkg::OP_COEF_WRITE, mcfir_pkg::SAMP_W'($urandom),
              mcfir_pkg::SAMP_W'($urandom), mcfir_pkg::SAMP_W'($urandom),
              mcfir_pkg::SAMP_W'($urandom), ch, tap, value);
    coefs_sent++;
  endtask

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_op           = mcfir_pkg::OP_SAMPLE_SET;
    in_sample_ch0   = '0;
    in_sample_ch1   = '0;
    in_sample_ch2   = '0;
    in_sample_ch3   = '0;
    in_coef_channel = '0;
    in_coef_tap     = '0;
    in_coef_value   = '0;
    idle_pct        = 0;
    stall_pct       = 0;
    hold_armed      = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // cleared stores, then extreme taps at both ends of the line
    send_set(10'd1023, 10'd1023, 10'd1023, 10'd1023);
    send_coef(2'd0, 5'd0, 16'sh7fff);
    send_coef(2'd1, 5'd0, 16'sh8000);
    send_coef(2'd2, 5'd31, 16'sh8000);
    send_coef(2'd3, 5'd31, 16'sh7fff);
    send_coef(2'd0, 5'd31, -16'sd1);
    send_coef(2'd3, 5'd0, 16'sd1);
    send_coef(2'd2, 5'd1, 16'sh5555);
    send_set(10'd1023, 10'd1023, 10'd1023, 10'd1023);
    send_set(10'd0, 10'd1023, 10'd0, 10'd1023);
    send_set(10'd1023, 10'd0, 10'd1023, 10'd0);
    send_set(10'd1, 10'd2, 10'd512, 10'd1022);
    send_coef(2'd1, 5'd16, 16'shaaaa);
    send_set(10'h155, 10'h2aa, 10'h3ff, 10'h000);
    send_set(10'h2aa, 10'h155, 10'h000, 10'h3ff);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 47; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 47; end
        default: begin idle_pct = 17; stall_pct = 17; end
      endcase
      if (phase == 0)
        hold_armed = 1'b1;
      // fill one channel with a single extreme value to push the sum to its limits
      for (int k = 0; k < mcfir_pkg::TAPS; k++)
        send_coef(2'(phase), 5'(k), (phase % 2 == 0) ? 16'sh8000 : 16'sh7fff);
      for (int n = mcfir_pkg::TAPS; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(99) < 30)
          send_coef(2'($urandom), 5'($urandom), pick_coef());
        else
          send_set(pick_sample(), pick_sample(), pick_sample(), pick_sample());
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (200) @(negedge clk);

    $display("%0d sample sets and %0d coefficient writes sent under four idle/stall mixes",
             sets_sent, coefs_sent);
    $display("%0d results compared, including a long receiver hold-off", checked);
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

[files.f]
hdl/mcfir_pkg.sv
hdl/mcfir_ram.sv
hdl/mcfir_ctrl.sv
hdl/mcfir_dp.sv
hdl/multichannel_fir_filter_unit.sv
hdl/mcfir_chk.sv
tb/mcfir_checker.sv
tb/tb.sv
